>>> src/pcr_pkg.sv
// ----------------------------------------------------------------------------
// pcr_pkg: shared definitions for the path capacity reservation unit
// Segment count, field widths and the sequencer state encoding.
// ----------------------------------------------------------------------------
package pcr_pkg;

  localparam int unsigned MAX_SEGMENTS = 2048;
  localparam int unsigned SEG_AW       = $clog2(MAX_SEGMENTS);
  localparam int unsigned PT_W         = 11;
  localparam int unsigned CAP_W        = 16;
  localparam int unsigned TOT_W        = 40;

  localparam logic [CAP_W-1:0] CAP_MAX = {CAP_W{1'b1}};
  localparam logic [TOT_W-1:0] TOT_MAX = {TOT_W{1'b1}};

  // Input transaction kinds
  localparam logic KIND_CLEAR   = 1'b0;
  localparam logic KIND_REQUEST = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLEAR,
    S_MIN,
    S_MIN_END,
    S_SUB,
    S_SUB_END
  } pcr_state_e;

endpackage

>>> src/path_capacity_reservation_unit.sv
// ----------------------------------------------------------------------------
// path_capacity_reservation_unit: greedy interval capacity allocation
// Per-segment remaining capacity held in one RAM; requests are served by a
// minimum pass and a subtract pass through a single read/write port pair.
// ----------------------------------------------------------------------------
// A request with a span of n segments runs a minimum pass, then a subtract pass.
// A clear writes every segment, one RAM write per cycle.
// An empty or out-of-range span gets its result in the cycle after acceptance.
// One transaction in flight; set by the RAM's single read and write port.
// Reset clears the sequencer, running total and capacity register; the
// segment RAM is not initialised and holds garbage until the first clear.
module path_capacity_reservation_unit
  import pcr_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  // configuration
  input  logic             cfg_we_i,
  input  logic [CAP_W-1:0] cfg_wdata_i,
  // input channel
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic             kind_i,
  input  logic [PT_W-1:0]  start_point_i,
  input  logic [PT_W-1:0]  end_point_i,
  input  logic [CAP_W-1:0] wanted_amount_i,
  // output channel
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [CAP_W-1:0] granted_amount_o,
  output logic [TOT_W-1:0] total_granted_o,
  output logic             bad_span_o
);

  // --------------------------------------------------------------------------
  // State
  // --------------------------------------------------------------------------
  pcr_state_e        state_q, state_d;
  logic [CAP_W-1:0]  seg_cap_q;
  logic [TOT_W-1:0]  total_q, total_d;

  // Walk pointer and span limits of the current request
  logic [SEG_AW-1:0] addr_q, addr_d;
  logic [SEG_AW-1:0] first_q, first_d;
  logic [SEG_AW-1:0] last_q, last_d;
  logic [CAP_W-1:0]  wanted_q, wanted_d;
  logic [CAP_W-1:0]  least_q, least_d;
  logic [CAP_W-1:0]  grant_q, grant_d;

  // Segment RAM, one read and one write port, registered read data
  logic [CAP_W-1:0]  seg_mem_q [MAX_SEGMENTS];
  logic [CAP_W-1:0]  rdata_q;
  logic              rd_vld_q, rd_vld_d;
  logic [SEG_AW-1:0] wr_addr_q;
  logic              mem_we;
  logic [SEG_AW-1:0] mem_waddr;
  logic [CAP_W-1:0]  mem_wdata;

  // Result register
  logic              out_valid_q, out_valid_d;
  logic [CAP_W-1:0]  granted_q, granted_d;
  logic [TOT_W-1:0]  tot_out_q, tot_out_d;
  logic              bad_q, bad_d;

  // --------------------------------------------------------------------------
  // Helpers
  // --------------------------------------------------------------------------
  logic              in_hs;
  logic              span_bad;
  logic [CAP_W-1:0]  least_fold;
  logic [TOT_W:0]    tot_sum;

  // Accept only when the result slot is free (or being drained this cycle)
  assign in_ready_o = (state_q == S_IDLE) && (!out_valid_q || out_ready_i);
  assign in_hs      = in_valid_i && in_ready_o;

  // Empty span, or a span running off the end of the path
  assign span_bad = (end_point_i <= start_point_i) ||
                    (32'(end_point_i) > 32'(MAX_SEGMENTS));

  // Fold the returning RAM word into the running minimum
  assign least_fold = (rd_vld_q && (rdata_q < least_q)) ? rdata_q : least_q;

  // Saturating accumulate: carry out means overflow
  assign tot_sum = {1'b0, total_q} + {{(TOT_W+1-CAP_W){1'b0}}, grant_q};

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_d     = state_q;
    total_d     = total_q;
    addr_d      = addr_q;
    first_d     = first_q;
    last_d      = last_q;
    wanted_d    = wanted_q;
    least_d     = least_q;
    grant_d     = grant_q;
    rd_vld_d    = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = addr_q;
    mem_wdata   = seg_cap_q;
    out_valid_d = out_valid_q && !out_ready_i;
    granted_d   = granted_q;
    tot_out_d   = tot_out_q;
    bad_d       = bad_q;

    case (state_q)
      S_IDLE: begin
        if (in_hs) begin
          if (kind_i == KIND_CLEAR) begin
            addr_d  = '0;
            state_d = S_CLEAR;
          end else if (span_bad) begin
            // flagged, no state change
            out_valid_d = 1'b1;
            granted_d   = '0;
            tot_out_d   = total_q;
            bad_d       = 1'b1;
          end else begin
            addr_d   = SEG_AW'(start_point_i);
            first_d  = SEG_AW'(start_point_i);
            last_d   = SEG_AW'(end_point_i - 1'b1);
            wanted_d = wanted_amount_i;
            least_d  = CAP_MAX;
            state_d  = S_MIN;
          end
        end
      end

      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = addr_q;
        mem_wdata = seg_cap_q;
        addr_d    = addr_q + 1'b1;
        if (addr_q == SEG_AW'(MAX_SEGMENTS - 1)) begin
          total_d     = '0;
          out_valid_d = 1'b1;
          granted_d   = '0;
          tot_out_d   = '0;
          bad_d       = 1'b0;
          state_d     = S_IDLE;
        end
      end

      S_MIN: begin
        rd_vld_d = 1'b1;
        least_d  = least_fold;
        addr_d   = addr_q + 1'b1;
        if (addr_q == last_q) begin
          state_d = S_MIN_END;
        end
      end

      S_MIN_END: begin
        // last word arrives here; grant = min(wanted, least)
        grant_d = (wanted_q < least_fold) ? wanted_q : least_fold;
        addr_d  = first_q;
        state_d = S_SUB;
      end

      S_SUB: begin
        // read segment i while writing back segment i-1
        rd_vld_d  = 1'b1;
        addr_d    = addr_q + 1'b1;
        mem_we    = rd_vld_q;
        mem_waddr = wr_addr_q;
        mem_wdata = rdata_q - grant_q;
        if (addr_q == last_q) begin
          state_d = S_SUB_END;
        end
      end

      S_SUB_END: begin
        mem_we      = 1'b1;
        mem_waddr   = wr_addr_q;
        mem_wdata   = rdata_q - grant_q;
        total_d     = tot_sum[TOT_W] ? TOT_MAX : tot_sum[TOT_W-1:0];
        out_valid_d = 1'b1;
        granted_d   = grant_q;
        tot_out_d   = tot_sum[TOT_W] ? TOT_MAX : tot_sum[TOT_W-1:0];
        bad_d       = 1'b0;
        state_d     = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Control registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      seg_cap_q   <= '0;
      total_q     <= '0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      total_q     <= total_d;
      rd_vld_q    <= rd_vld_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        seg_cap_q <= cfg_wdata_i;
      end
    end
  end

  // Datapath registers, no reset needed
  always_ff @(posedge clk_i) begin
    addr_q    <= addr_d;
    first_q   <= first_d;
    last_q    <= last_d;
    wanted_q  <= wanted_d;
    least_q   <= least_d;
    grant_q   <= grant_d;
    wr_addr_q <= addr_q;
    granted_q <= granted_d;
    tot_out_q <= tot_out_d;
    bad_q     <= bad_d;
  end

  // --------------------------------------------------------------------------
  // Segment RAM
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      seg_mem_q[mem_waddr] <= mem_wdata;
    end
    rdata_q <= seg_mem_q[addr_q];
  end

  // --------------------------------------------------------------------------
  // Outputs
  // --------------------------------------------------------------------------
  assign out_valid_o      = out_valid_q;
  assign granted_amount_o = granted_q;
  assign total_granted_o  = tot_out_q;
  assign bad_span_o       = bad_q;

endmodule

>>> src/pcr_checker.sv
// ----------------------------------------------------------------------------
// pcr_checker: port-level checks for the path capacity reservation unit
// Watches the top-level ports only; attached to the top level by bind.
// ----------------------------------------------------------------------------
module pcr_checker
  import pcr_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_ready_o,
  input logic             out_valid_o,
  input logic             out_ready_i,
  input logic [CAP_W-1:0] granted_amount_o,
  input logic [TOT_W-1:0] total_granted_o,
  input logic             bad_span_o
);

  // A stalled result transaction holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(granted_amount_o) && $stable(total_granted_o) &&
      $stable(bad_span_o))
    else $error("result changed while stalled");

  // Never take a new transaction while the result slot stays full
  a_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> (!out_valid_o || out_ready_i))
    else $error("input accepted with result slot blocked");

  // Flagged spans reserve nothing
  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && bad_span_o |-> (granted_amount_o == '0))
    else $error("grant on flagged span");

  // Running total always covers the latest grant
  a_tot_cover: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      (total_granted_o >= {{(TOT_W-CAP_W){1'b0}}, granted_amount_o}))
    else $error("total below grant");

endmodule

bind path_capacity_reservation_unit pcr_checker u_pcr_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_ready_o       (in_ready_o),
  .out_valid_o      (out_valid_o),
  .out_ready_i      (out_ready_i),
  .granted_amount_o (granted_amount_o),
  .total_granted_o  (total_granted_o),
  .bad_span_o       (bad_span_o)
);
